// File: design/psp_pkg.sv
// Package for the polyphonic sample player core.
// Holds payload structs, fixed-point constants and the pad-to-pitch lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psp_pkg;

  localparam int unsigned VoiceCountDef   = 8;
  localparam int unsigned BlockSamplesDef = 32;
  localparam int unsigned SampleWordsDef  = 32768;

  // 1.16 level and 2.16 speed constants
  localparam logic [16:0] Unity      = 17'd65536;
  localparam logic [16:0] LevelStep  = 17'd164;
  localparam logic [16:0] LevelFloor = 17'd66;
  localparam logic [17:0] SpeedUnity = 18'd65536;

  // 160000 * 65536: divisor for one counted voice
  localparam logic [63:0] DenUnit = 64'd10485760000;

  localparam logic [15:0] VolumeReset = 16'd8000;
  localparam logic [53:0] PitchReset3 = 54'd4503616807305216;
  localparam logic [53:0] PitchReset2 = 54'd17179934720;

  // Configuration register indexes
  localparam logic [2:0] RegLength  = 3'd0;
  localparam logic [2:0] RegVolume  = 3'd1;
  localparam logic [2:0] RegPitch13 = 3'd2;
  localparam logic [2:0] RegPitch46 = 3'd3;
  localparam logic [2:0] RegPitch79 = 3'd4;
  localparam logic [2:0] RegPitchAB = 3'd5;

  // Input command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdTick  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [11:0]        pad_mask;
    logic [14:0]        write_address;
    logic signed [15:0] write_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               last_in_block;
  } out_beat_t;

  // Pitch register (0..3) that holds the speed of a pad
  function automatic logic [1:0] pad_reg(input logic [3:0] pad);
    logic [3:0] k;
    k = pad - 4'd1;
    if (k < 4'd3) return 2'd0;
    else if (k < 4'd6) return 2'd1;
    else if (k < 4'd9) return 2'd2;
    else return 2'd3;
  endfunction

  // Slot (0..2) of a pad within its pitch register
  function automatic logic [1:0] pad_slot(input logic [3:0] pad);
    logic [3:0] k;
    k = pad - 4'd1;
    if (k < 4'd3) return k[1:0];
    else if (k < 4'd6) return 2'(k - 4'd3);
    else if (k < 4'd9) return 2'(k - 4'd6);
    else return 2'(k - 4'd9);
  endfunction

endpackage
`default_nettype wire

// File: design/psp_ram.sv
// Generic simple dual-port RAM with a registered read.
// One write port and one read port; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module psp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write first port, registered read on the second
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: design/polyphonic_sample_player_core.sv
// Polyphonic sample player top level: voice sequencer, mixer and scaler.
// Depends on psp_pkg and psp_ram (sample memory).
//
//  Channel | Signals                         | Beat
//  --------+---------------------------------+------------------------------
//  in      | in_valid_i/in_ready_o/in_data_i | sample write or block tick
//  out     | out_valid_o/out_ready_i/out_data_o | one mixed sample
//  cfg     | cfg_valid_i/cfg_ready_o/cfg_*_i | register write, always ready
//
// A sample write is taken while the sequencer is idle. A tick first runs pad start,
// then per output sample steps through the voices (two sample memory reads for each
// sounding voice), then scales and divides. Pad bit 0 clears all voices and emits silence.
// Reset clears all voices; the sample memory is not cleared.
// A stalled output holds the sequencer only when the next sample is ready.
`timescale 1ns / 1ps
`default_nettype none
module polyphonic_sample_player_core
  import psp_pkg::*;
#(
  parameter int unsigned VOICE_COUNT   = VoiceCountDef,
  parameter int unsigned BLOCK_SAMPLES = BlockSamplesDef,
  parameter int unsigned SAMPLE_WORDS  = SampleWordsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [53:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(SAMPLE_WORDS);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned PW = LW + 16;
  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned CW = $clog2(VOICE_COUNT + 1);
  localparam int unsigned BW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
  localparam int unsigned MW = 40;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RELEASE, S_RAMP, S_S0, S_S1, S_ACC,
    S_MUL1, S_MUL2, S_DIV, S_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [15:0] length_q, volume_q;
  logic [53:0] pitch_q [4];

  // Voice state
  logic          vact_q  [VOICE_COUNT];
  logic [3:0]    vpad_q  [VOICE_COUNT];
  logic [PW-1:0] vpos_q  [VOICE_COUNT];
  logic [17:0]   vspd_q  [VOICE_COUNT];
  logic [16:0]   vlvl_q  [VOICE_COUNT];
  logic          vton_q  [VOICE_COUNT];

  // Sequencer working registers
  logic [15:0]        mask_q;
  logic [3:0]         pad_q;
  logic [VW-1:0]      v_q;
  logic [BW-1:0]      smp_q;
  logic               mute_q;
  logic [CW-1:0]      cnt_q;
  logic signed [MW-1:0] mix_q;
  logic [LW-1:0]      idx0_q;
  logic [15:0]        frac_q;
  logic [16:0]        lvl_q;
  logic signed [15:0] s0_q;
  logic               s1ok_q;
  logic signed [33:0] prod_q;
  logic [63:0]        num_q, den_q;
  logic               neg_q;
  logic [3:0]         bit_q;
  logic [14:0]        quo_q;
  out_beat_t          out_q;
  logic               out_valid_q;

  // Effective sample length, capped at the memory size
  logic [LW-1:0] len;
  always_comb begin
    if ({1'b0, length_q} > 17'(SAMPLE_WORDS)) len = LW'(SAMPLE_WORDS);
    else len = LW'(length_q);
  end

  // Level ramp and position step for the voice under the sequencer
  logic [16:0]   lvl_new;
  logic [17:0]   lvl_up;
  logic [LW-1:0] idx0;
  logic [PW:0]   pos_sum;
  logic [PW-1:0] pos_lim, pos_new;
  always_comb begin
    lvl_up = {1'b0, vlvl_q[v_q]} + {1'b0, LevelStep};
    if (vton_q[v_q]) begin
      if (lvl_up > {1'b0, Unity}) lvl_new = Unity;
      else lvl_new = lvl_up[16:0];
    end else begin
      if (vlvl_q[v_q] > LevelStep) lvl_new = vlvl_q[v_q] - LevelStep;
      else lvl_new = '0;
    end
    idx0    = vpos_q[v_q][PW-1:16];
    pos_sum = {1'b0, vpos_q[v_q]} + (PW+1)'(vspd_q[v_q]);
    pos_lim = {len, 16'd0};
    pos_new = (pos_sum > {1'b0, pos_lim}) ? pos_lim : pos_sum[PW-1:0];
  end

  // Pad start: is the pad playing, and the lowest free voice
  logic          pad_playing, free_found;
  logic [VW-1:0] free_v;
  always_comb begin
    pad_playing = 1'b0;
    free_found  = 1'b0;
    free_v      = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (vact_q[v] && vpad_q[v] == pad_q) pad_playing = 1'b1;
      if (!vact_q[v]) begin
        free_found = 1'b1;
        free_v     = VW'(v);
      end
    end
  end

  logic [17:0] pad_speed;
  assign pad_speed = 18'(pitch_q[pad_reg(pad_q)] >> (6'd18 * 6'(pad_slot(pad_q))));

  // Interpolation and weighting arithmetic
  logic [15:0]        rd_data;
  logic signed [15:0] s1;
  logic signed [16:0] diff;
  logic signed [33:0] interp;
  logic signed [51:0] term;
  logic [MW-1:0]      mag;
  logic [63:0]        den_sh;
  assign s1     = s1ok_q ? signed'(rd_data) : 16'sd0;
  assign diff   = 17'(s1) - 17'(s0_q);
  assign interp = (34'(s0_q) <<< 16) + prod_q;
  assign term   = 52'(interp) * 52'(signed'({1'b0, lvl_q}));
  assign mag    = mix_q[MW-1] ? MW'(-mix_q) : MW'(mix_q);
  assign den_sh = den_q << bit_q;

  // Sample memory
  logic          ram_we;
  logic [16:0]   waddr_ext;
  logic [AW-1:0] ram_raddr;
  logic [LW:0]   idx1;
  assign waddr_ext = 17'(in_data_i.write_address);
  assign ram_we    = in_valid_i && in_ready_o && in_data_i.cmd == CmdWrite &&
                     waddr_ext < 17'(SAMPLE_WORDS);
  assign idx1      = (LW+1)'(idx0_q) + (LW+1)'(1);
  assign ram_raddr = (state_q == S_S0) ? idx1[AW-1:0] : idx0[AW-1:0];

  psp_ram #(.Width(16), .Depth(SAMPLE_WORDS)) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr_ext[AW-1:0]),
    .wdata_i(in_data_i.write_value),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q   <= '0;
      volume_q   <= VolumeReset;
      pitch_q[0] <= PitchReset3;
      pitch_q[1] <= PitchReset3;
      pitch_q[2] <= PitchReset3;
      pitch_q[3] <= PitchReset2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegLength:  length_q   <= cfg_data_i[15:0];
        RegVolume:  volume_q   <= cfg_data_i[15:0];
        RegPitch13: pitch_q[0] <= cfg_data_i;
        RegPitch46: pitch_q[1] <= cfg_data_i;
        RegPitch79: pitch_q[2] <= cfg_data_i;
        RegPitchAB: pitch_q[3] <= {18'd0, cfg_data_i[35:0]};
        default: ;
      endcase
    end
  end

  // Sequencer, voice state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        vact_q[v] <= 1'b0;
        vpad_q[v] <= '0;
        vpos_q[v] <= '0;
        vspd_q[v] <= SpeedUnity;
        vlvl_q[v] <= '0;
        vton_q[v] <= 1'b0;
      end
      mask_q <= '0; pad_q <= '0; v_q <= '0; smp_q <= '0; mute_q <= 1'b0;
      cnt_q <= '0; mix_q <= '0; bit_q <= '0; quo_q <= '0; neg_q <= 1'b0;
      idx0_q <= '0; frac_q <= '0; lvl_q <= '0; s0_q <= '0; s1ok_q <= 1'b0;
      prod_q <= '0; num_q <= '0; den_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_data_i.cmd == CmdTick) begin
            mask_q <= {4'd0, in_data_i.pad_mask};
            smp_q  <= '0;
            pad_q  <= 4'd1;
            quo_q  <= '0;
            neg_q  <= 1'b0;
            mute_q <= in_data_i.pad_mask[0];
            if (in_data_i.pad_mask[0]) begin
              for (int v = 0; v < VOICE_COUNT; v++) begin
                vact_q[v] <= 1'b0;
                vlvl_q[v] <= '0;
                vton_q[v] <= 1'b0;
              end
              state_q <= S_EMIT;
            end else begin
              state_q <= S_START;
            end
          end
        end
        // One pad a cycle, pads one to eleven
        S_START: begin
          if (mask_q[pad_q] && !pad_playing && free_found) begin
            vact_q[free_v] <= 1'b1;
            vpad_q[free_v] <= pad_q;
            vpos_q[free_v] <= '0;
            vspd_q[free_v] <= pad_speed;
            vlvl_q[free_v] <= '0;
            vton_q[free_v] <= 1'b1;
          end
          if (pad_q == 4'd11) state_q <= S_RELEASE;
          pad_q <= pad_q + 4'd1;
        end
        S_RELEASE: begin
          for (int v = 0; v < VOICE_COUNT; v++) begin
            if (vact_q[v] && !mask_q[vpad_q[v]]) vton_q[v] <= 1'b0;
          end
          v_q <= '0; cnt_q <= '0; mix_q <= '0;
          state_q <= S_RAMP;
        end
        // Ramp level, retire or start the two reads of one voice
        S_RAMP: begin
          logic done;
          done = 1'b1;
          if (vact_q[v_q]) begin
            vlvl_q[v_q] <= lvl_new;
            if (!vton_q[v_q] && lvl_new < LevelFloor) begin
              vact_q[v_q] <= 1'b0;
            end else if (lvl_new >= LevelFloor) begin
              cnt_q <= cnt_q + CW'(1);
              if (idx0 >= len) begin
                vact_q[v_q] <= 1'b0;
              end else begin
                idx0_q      <= idx0;
                frac_q      <= vpos_q[v_q][15:0];
                lvl_q       <= lvl_new;
                vpos_q[v_q] <= pos_new;
                done        = 1'b0;
                state_q     <= S_S0;
              end
            end
          end
          if (done) begin
            if (v_q == VW'(VOICE_COUNT - 1)) state_q <= S_MUL1;
            else v_q <= v_q + VW'(1);
          end
        end
        S_S0: begin
          s0_q    <= signed'(rd_data);
          s1ok_q  <= idx1 < (LW+1)'(len);
          state_q <= S_S1;
        end
        S_S1: begin
          prod_q  <= 34'(signed'({1'b0, frac_q})) * 34'(diff);
          state_q <= S_ACC;
        end
        S_ACC: begin
          mix_q <= mix_q + MW'(term >>> 16);
          if (v_q == VW'(VOICE_COUNT - 1)) state_q <= S_MUL1;
          else begin
            v_q     <= v_q + VW'(1);
            state_q <= S_RAMP;
          end
        end
        // Magnitude times volume, and the divisor for the voice count
        S_MUL1: begin
          num_q   <= 64'(mag) * 64'(volume_q);
          neg_q   <= mix_q[MW-1];
          den_q   <= DenUnit * 64'((cnt_q == '0) ? CW'(1) : cnt_q);
          quo_q   <= '0;
          bit_q   <= 4'd15;
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          num_q   <= (num_q << 4) + num_q;
          state_q <= S_DIV;
        end
        // Restoring division, one quotient bit a cycle
        S_DIV: begin
          if (bit_q == 4'd15) begin
            if (num_q >= den_sh) begin
              quo_q   <= 15'h7FFF;
              state_q <= S_EMIT;
            end else begin
              bit_q <= 4'd14;
            end
          end else begin
            if (num_q >= den_sh) begin
              num_q        <= num_q - den_sh;
              quo_q[bit_q] <= 1'b1;
            end
            if (bit_q == 4'd0) state_q <= S_EMIT;
            else bit_q <= bit_q - 4'd1;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.out_sample    <= neg_q ? -16'(quo_q) : 16'(quo_q);
            out_q.last_in_block <= (smp_q == BW'(BLOCK_SAMPLES - 1));
            if (smp_q == BW'(BLOCK_SAMPLES - 1)) begin
              state_q <= S_IDLE;
            end else begin
              smp_q <= smp_q + BW'(1);
              if (!mute_q) begin
                v_q <= '0; cnt_q <= '0; mix_q <= '0;
                state_q <= S_RAMP;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The counted voices never exceed the voice count
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(VOICE_COUNT)) else $error("voice count overflow");

  // A sample is only emitted when the output register is free or drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q)) else $error("output overwritten");

  // The first read of a voice is issued only below the sample length
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_S0 |-> idx0_q < len) else $error("read beyond sample length");

  // After the saturation check the remainder stays below the top weight
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && bit_q != 4'd15) |-> num_q < (den_q << 15))
    else $error("division out of range");

endmodule
`default_nettype wire
